// ===== design/ptw_pkg.sv =====
// Package for the four-level page table engine: pool geometry, opcode and status codes,
// and the command and status structs that pass between controller and datapath.
// Depends on nothing.
`default_nettype none

package ptw_pkg;

   localparam int TABLE_PAGES       = 64;
   localparam int LEVELS            = 4;

   localparam int ENTRY_W           = 64;
   localparam int VA_W              = 48;
   localparam int PA_W              = 52;
   localparam int FLAG_W            = 12;
   localparam int OP_W              = 2;
   localparam int STATUS_W          = 3;
   localparam int OFFSET_W          = 12;
   localparam int IDX_W             = 9;
   localparam int ENTRIES_PER_TABLE = 1 << IDX_W;

   localparam int LEVEL_W    = $clog2(LEVELS);
   localparam int PAGE_IDX_W = $clog2(TABLE_PAGES);
   localparam int PAGE_CNT_W = $clog2(TABLE_PAGES + 1);
   localparam int ADDR_W     = PAGE_IDX_W + IDX_W;
   localparam int MEM_DEPTH  = TABLE_PAGES * ENTRIES_PER_TABLE;

   localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
   localparam logic [OP_W-1:0] OP_UNMAP  = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REMAP     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_VALID = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd4;

   localparam logic [1:0] WR_PTR  = 2'd0;
   localparam logic [1:0] WR_LEAF = 2'd1;
   localparam logic [1:0] WR_ZERO = 2'd2;

   typedef struct packed {
      logic                load_req;
      logic                rd_en;
      logic                wr_en;
      logic [1:0]          wr_sel;
      logic                descend;
      logic                alloc;
      logic                set_result;
      logic [STATUS_W-1:0] res_status;
      logic                res_mapped;
      logic                res_flush;
      logic                push;
      logic                clear_wr;
   } cmd_type;

   typedef struct packed {
      logic            entry_valid;
      logic            ptr_oor;
      logic            pool_full;
      logic            lvl_zero;
      logic [OP_W-1:0] opcode;
      logic            out_free;
      logic            clear_last;
   } sts_type;

endpackage

`default_nettype wire

// ===== design/ptw_datapath.sv =====
// Datapath of the page table engine: table pool memory, request and walk registers,
// bump allocator, result and output registers. Driven by ptw_ctrl; uses ptw_pkg.
`default_nettype none

module ptw_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire ptw_pkg::cmd_type            cmd,
   output ptw_pkg::sts_type                 sts,
   input  wire [ptw_pkg::OP_W-1:0]          req_opcode,
   input  wire [ptw_pkg::VA_W-1:0]          req_virt_addr,
   input  wire [ptw_pkg::PA_W-1:0]          req_phys_addr,
   input  wire [ptw_pkg::FLAG_W-1:0]        req_flags,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic [ptw_pkg::STATUS_W-1:0]     rsp_status,
   output logic                             rsp_mapped,
   output logic [ptw_pkg::PA_W-1:0]         rsp_page_base,
   output logic                             rsp_tlb_flush
);
   import ptw_pkg::*;

   logic [ENTRY_W-1:0]    mem [MEM_DEPTH];
   logic [ENTRY_W-1:0]    rd_data_ff;

   logic [OP_W-1:0]       op_ff;
   logic [VA_W-1:0]       va_ff;
   logic [PA_W-1:0]       pa_ff;
   logic [FLAG_W-1:0]     fl_ff;
   logic [LEVEL_W-1:0]    lvl_ff;
   logic [PAGE_IDX_W-1:0] page_ff;
   logic [PAGE_IDX_W-1:0] page_in;
   logic [PAGE_CNT_W-1:0] next_free_ff;
   logic [ADDR_W-1:0]     clr_cnt_ff;

   logic [STATUS_W-1:0]   res_status_ff;
   logic                  res_mapped_ff;
   logic                  res_flush_ff;
   logic [PA_W-1:0]       res_base_ff;

   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_mapped_ff;
   logic [PA_W-1:0]       rsp_base_ff;
   logic                  rsp_flush_ff;

   logic [IDX_W-1:0]      walk_idx;
   logic [ADDR_W-1:0]     mem_addr;
   logic [ENTRY_W-1:0]    wr_data;
   logic                  mem_we;
   logic                  pool_full;
   logic                  out_free;

   assign walk_idx  = va_ff[OFFSET_W + IDX_W * lvl_ff +: IDX_W];
   assign mem_addr  = cmd.clear_wr ? clr_cnt_ff : {page_ff, walk_idx};
   assign mem_we    = cmd.wr_en | cmd.clear_wr;
   assign pool_full = next_free_ff >= PAGE_CNT_W'(TABLE_PAGES);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign page_in   = cmd.alloc ? next_free_ff[PAGE_IDX_W-1:0]
                                : rd_data_ff[OFFSET_W +: PAGE_IDX_W];

   always_comb begin
      wr_data = '0;
      if (!cmd.clear_wr) begin
         case (cmd.wr_sel)
            WR_PTR:  wr_data = (ENTRY_W'(next_free_ff[PAGE_IDX_W-1:0]) << OFFSET_W)
                               | ENTRY_W'(1);
            WR_LEAF: wr_data = {(ENTRY_W - PA_W)'(0), pa_ff[PA_W-1:OFFSET_W],
                                fl_ff | FLAG_W'(1)};
            default: wr_data = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_opcode;
         va_ff <= req_virt_addr;
         pa_ff <= req_phys_addr;
         fl_ff <= req_flags;
      end
      if (cmd.load_req) begin
         lvl_ff  <= LEVEL_W'(LEVELS - 1);
         page_ff <= '0;
      end else if (cmd.descend) begin
         lvl_ff  <= lvl_ff - LEVEL_W'(1);
         page_ff <= page_in;
      end
      if (cmd.set_result) begin
         res_status_ff <= cmd.res_status;
         res_mapped_ff <= cmd.res_mapped;
         res_flush_ff  <= cmd.res_flush;
         res_base_ff   <= cmd.res_mapped ? {rd_data_ff[PA_W-1:OFFSET_W], OFFSET_W'(0)}
                                         : '0;
      end
      if (cmd.push) begin
         rsp_status_ff <= res_status_ff;
         rsp_mapped_ff <= res_mapped_ff;
         rsp_base_ff   <= res_base_ff;
         rsp_flush_ff  <= res_flush_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_free_ff <= PAGE_CNT_W'(1);
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.alloc) begin
            next_free_ff <= next_free_ff + PAGE_CNT_W'(1);
         end
         if (cmd.clear_wr) begin
            clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
         end
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      sts.entry_valid = rd_data_ff[0];
      sts.ptr_oor     = rd_data_ff[ENTRY_W-1:OFFSET_W] >= (ENTRY_W - OFFSET_W)'(TABLE_PAGES);
      sts.pool_full   = pool_full;
      sts.lvl_zero    = lvl_ff == '0;
      sts.opcode      = op_ff;
      sts.out_free    = out_free;
      sts.clear_last  = clr_cnt_ff == ADDR_W'(MEM_DEPTH - 1);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_mapped    = rsp_mapped_ff;
   assign rsp_page_base = rsp_base_ff;
   assign rsp_tlb_flush = rsp_flush_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      next_free_ff <= PAGE_CNT_W'(TABLE_PAGES))
      else $error("bump counter beyond pool");

   a_alloc_room: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> !pool_full)
      else $error("table allocated from a full pool");

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> out_free)
      else $error("result beat overwritten while stalled");

endmodule

`default_nettype wire

// ===== design/ptw_ctrl.sv =====
// Controller of the page table engine: reset clearing sweep, walk sequencing and result
// decisions. Commands ptw_datapath through ptw_pkg::cmd_type.
`default_nettype none

module ptw_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire ptw_pkg::sts_type sts,
   output ptw_pkg::cmd_type cmd
);
   import ptw_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_PUSH  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_READ;
            end
         end
         S_READ: begin
            if (sts.opcode == OP_NOP) begin
               cmd.set_result = 1'b1;
               state_in       = S_PUSH;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            if (!sts.lvl_zero) begin
               if (sts.entry_valid) begin
                  if (sts.ptr_oor) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = ST_MISSING;
                     state_in       = S_PUSH;
                  end else begin
                     cmd.descend = 1'b1;
                     state_in    = S_READ;
                  end
               end else if (sts.opcode == OP_MAP) begin
                  if (sts.pool_full) begin
                     cmd.set_result = 1'b1;
                     cmd.res_status = ST_EXHAUSTED;
                     state_in       = S_PUSH;
                  end else begin
                     cmd.wr_en   = 1'b1;
                     cmd.wr_sel  = WR_PTR;
                     cmd.alloc   = 1'b1;
                     cmd.descend = 1'b1;
                     state_in    = S_READ;
                  end
               end else begin
                  cmd.set_result = 1'b1;
                  cmd.res_status = ST_MISSING;
                  state_in       = S_PUSH;
               end
            end else begin
               cmd.set_result = 1'b1;
               state_in       = S_PUSH;
               case (sts.opcode)
                  OP_MAP: begin
                     if (sts.entry_valid) begin
                        cmd.res_status = ST_REMAP;
                     end else begin
                        cmd.wr_en     = 1'b1;
                        cmd.wr_sel    = WR_LEAF;
                        cmd.res_flush = 1'b1;
                     end
                  end
                  OP_UNMAP: begin
                     cmd.wr_en      = 1'b1;
                     cmd.wr_sel     = WR_ZERO;
                     cmd.res_flush  = 1'b1;
                     cmd.res_status = sts.entry_valid ? ST_OK : ST_NOT_VALID;
                  end
                  OP_LOOKUP: begin
                     cmd.res_mapped = sts.entry_valid;
                     cmd.res_status = sts.entry_valid ? ST_OK : ST_NOT_VALID;
                  end
                  default: begin
                     cmd.res_status = ST_OK;
                  end
               endcase
            end
         end
         S_PUSH: begin
            if (sts.out_free) begin
               cmd.push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EVAL |-> $past(state_ff) == S_READ)
      else $error("entry evaluated without a table read");

   a_descend_level: assert property (@(posedge clock) disable iff (reset)
      cmd.descend |-> !sts.lvl_zero)
      else $error("walk descended below the leaf level");

   a_write_in_eval: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_en |-> state_ff == S_EVAL)
      else $error("table write outside the decide step");

endmodule

`default_nettype wire

// ===== design/page_table_walk_map_unmap_top.sv =====
// Top level of the four-level page table engine: joins ptw_ctrl and ptw_datapath.
// Uses ptw_pkg for field widths.
//
// Usage:
//   req_ channel: one beat is a map, unmap or lookup (req_opcode) for req_virt_addr,
//   with req_phys_addr and req_flags used by map. Opcode 3 gives an all-zero result.
//   rsp_ channel: one beat per request, in order: rsp_status, rsp_mapped,
//   rsp_page_base, rsp_tlb_flush.
//   After reset the table pool (TABLE_PAGES x 512 entries, 32768 at 64 pages) is
//   swept to zero, one entry a cycle; req_stall stays high until the sweep ends.
//   The root table is page 0 and the allocator starts at page 1.
//   Each walk level is a read step and a decide step on the single-port pool memory,
//   so a full four-level walk reads the pool four times before its result beat; a walk
//   that stops early skips the levels left, and opcode 3 does no read. A new request is
//   taken only once the previous walk has ended, as the controller runs one walk at a
//   time through the dependent read chain in the pool.
//   The result beat sits in an output register; the next request is taken while it
//   waits. If rsp_stall holds that register, a finished result waits in the
//   datapath and req_stall stays high until the output register frees.
`default_nettype none

module page_table_walk_map_unmap_top (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire [ptw_pkg::OP_W-1:0]      req_opcode,
   input  wire [ptw_pkg::VA_W-1:0]      req_virt_addr,
   input  wire [ptw_pkg::PA_W-1:0]      req_phys_addr,
   input  wire [ptw_pkg::FLAG_W-1:0]    req_flags,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [ptw_pkg::STATUS_W-1:0] rsp_status,
   output logic                         rsp_mapped,
   output logic [ptw_pkg::PA_W-1:0]     rsp_page_base,
   output logic                         rsp_tlb_flush
);
   import ptw_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptw_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_opcode    (req_opcode),
      .req_virt_addr (req_virt_addr),
      .req_phys_addr (req_phys_addr),
      .req_flags     (req_flags),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_mapped    (rsp_mapped),
      .rsp_page_base (rsp_page_base),
      .rsp_tlb_flush (rsp_tlb_flush)
   );

endmodule

`default_nettype wire

// ===== verif/page_table_walk_map_unmap_top_tb.sv =====
// Testbench for page_table_walk_map_unmap_top: directed, pool exhaustion, back-pressure and
// random map/unmap/lookup traffic, checked beat by beat against a mirror of the table pool.
// Depends on ptw_pkg and the page_table_walk_map_unmap_top RTL.
module page_table_walk_map_unmap_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ptw_pkg::*;

   localparam int unsigned RUN_LIMIT    = 1000000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned RANDOM_ITEMS = 1070;
   localparam int unsigned HOLDOFF_LEN  = 300;
   localparam int          PATH_LSB     = OFFSET_W + IDX_W;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                mapped;
      logic [PA_W-1:0]     page_base;
      logic                tlb_flush;
   } walk_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_opcode = OP_NOP;
   logic [VA_W-1:0]     req_virt_addr = '0;
   logic [PA_W-1:0]     req_phys_addr = '0;
   logic [FLAG_W-1:0]   req_flags = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_mapped;
   logic [PA_W-1:0]     rsp_page_base;
   logic                rsp_tlb_flush;

   bit [ENTRY_W-1:0]          pool_mirror [MEM_DEPTH];
   int unsigned               mirror_next_page = 1;
   walk_result_type           awaited_walk_results [$];
   logic [VA_W-PATH_LSB-1:0]  leaf_paths [$];
   logic [VA_W-1:0]           recent_maps [$];

   int unsigned send_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned holdoff_cycles = 0;
   int unsigned cycle_count = 0;
   int          error_count = 0;

   page_table_walk_map_unmap_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_virt_addr (req_virt_addr),
      .req_phys_addr (req_phys_addr),
      .req_flags     (req_flags),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_mapped    (rsp_mapped),
      .rsp_page_base (rsp_page_base),
      .rsp_tlb_flush (rsp_tlb_flush)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("page_table_walk_map_unmap_top verification failed");
         $finish;
      end
   end

   function automatic int unsigned idle_length(input int unsigned pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(16, 60);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [STATUS_W-1:0] mirror_walk(input logic [VA_W-1:0] va,
         input bit grow, output int unsigned slot);
      int unsigned      page;
      int unsigned      pos;
      bit [ENTRY_W-1:0] entry;
      page = 0;
      slot = 0;
      for (int lvl = LEVELS - 1; lvl > 0; lvl--) begin
         pos = page * ENTRIES_PER_TABLE + va[OFFSET_W + IDX_W * lvl +: IDX_W];
         entry = pool_mirror[pos];
         if (entry[0]) begin
            if (entry[ENTRY_W-1:OFFSET_W] >= TABLE_PAGES) return ST_MISSING;
            page = 32'(entry[OFFSET_W +: PAGE_IDX_W]);
         end else if (grow) begin
            if (mirror_next_page >= TABLE_PAGES) return ST_EXHAUSTED;
            page = mirror_next_page;
            mirror_next_page++;
            for (int i = 0; i < ENTRIES_PER_TABLE; i++)
               pool_mirror[page * ENTRIES_PER_TABLE + i] = '0;
            pool_mirror[pos] = (ENTRY_W'(page) << OFFSET_W) | ENTRY_W'(1);
         end else begin
            return ST_MISSING;
         end
      end
      slot = page * ENTRIES_PER_TABLE + va[OFFSET_W +: IDX_W];
      return ST_OK;
   endfunction

   function automatic walk_result_type predict_walk_result(input logic [OP_W-1:0] op,
         input logic [VA_W-1:0] va, input logic [PA_W-1:0] pa, input logic [FLAG_W-1:0] fl);
      walk_result_type  res;
      int unsigned      slot;
      bit [ENTRY_W-1:0] leaf;
      res = '0;
      case (op)
         OP_MAP: begin
            res.status = mirror_walk(va, 1'b1, slot);
            if (res.status == ST_OK) begin
               if (pool_mirror[slot][0]) begin
                  res.status = ST_REMAP;
               end else begin
                  pool_mirror[slot] = {12'h000, pa[PA_W-1:OFFSET_W], fl | 12'h001};
                  res.tlb_flush = 1'b1;
               end
            end
         end
         OP_UNMAP: begin
            res.status = mirror_walk(va, 1'b0, slot);
            if (res.status == ST_OK) begin
               if (!pool_mirror[slot][0]) res.status = ST_NOT_VALID;
               pool_mirror[slot] = '0;
               res.tlb_flush = 1'b1;
            end
         end
         OP_LOOKUP: begin
            res.status = mirror_walk(va, 1'b0, slot);
            if (res.status == ST_OK) begin
               leaf = pool_mirror[slot];
               if (leaf[0]) begin
                  res.mapped = 1'b1;
                  res.page_base = {leaf[PA_W-1:OFFSET_W], 12'h000};
               end else begin
                  res.status = ST_NOT_VALID;
               end
            end
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [VA_W-1:0] va,
         input logic [PA_W-1:0] pa, input logic [FLAG_W-1:0] fl);
      int unsigned     gap;
      int unsigned     pages_before;
      walk_result_type want;
      gap = idle_length(send_idle_pct);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_virt_addr <= va;
      req_phys_addr <= pa;
      req_flags     <= fl;
      do @(posedge clock); while (req_stall !== 1'b0);
      pages_before = mirror_next_page;
      want = predict_walk_result(op, va, pa, fl);
      awaited_walk_results.push_back(want);
      if (op == OP_MAP && want.status == ST_OK) begin
         if (mirror_next_page != pages_before) leaf_paths.push_back(va[VA_W-1:PATH_LSB]);
         recent_maps.push_back(va);
         if (recent_maps.size() > 64) void'(recent_maps.pop_front());
      end
   endtask

   function automatic logic [VA_W-1:0] pick_virt_addr();
      logic [VA_W-1:0] va;
      int unsigned     sel;
      va = VA_W'({$urandom, $urandom});
      sel = $urandom_range(0, 99);
      if (sel < 55 && leaf_paths.size() > 0) begin
         va[VA_W-1:PATH_LSB] = leaf_paths[$urandom_range(0, leaf_paths.size() - 1)];
         case ($urandom_range(0, 3))
            0: va[OFFSET_W +: IDX_W] = '0;
            1: va[OFFSET_W +: IDX_W] = '1;
            default: va[OFFSET_W +: IDX_W] = IDX_W'($urandom_range(0, 7));
         endcase
      end else if (sel < 80 && recent_maps.size() > 0) begin
         va[VA_W-1:OFFSET_W] =
            recent_maps[$urandom_range(0, recent_maps.size() - 1)][VA_W-1:OFFSET_W];
      end else if (sel >= 92) begin
         for (int lvl = 0; lvl < LEVELS; lvl++)
            va[OFFSET_W + IDX_W * lvl +: IDX_W] = {IDX_W{1'($urandom_range(0, 1))}};
      end
      return va;
   endfunction

   task automatic send_random_request();
      int unsigned     sel;
      logic [OP_W-1:0] op;
      sel = $urandom_range(0, 99);
      if (sel < 35) op = OP_MAP;
      else if (sel < 60) op = OP_UNMAP;
      else if (sel < 95) op = OP_LOOKUP;
      else op = OP_NOP;
      send_request(op, pick_virt_addr(), PA_W'({$urandom, $urandom}), FLAG_W'($urandom));
   endtask

   task automatic check_field(input string field, input logic [63:0] want,
         input logic [63:0] got);
      if (got !== want) begin
         $display("%0t rsp_%s mismatch: expected 0x%0h actual 0x%0h", $time, field, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      walk_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (awaited_walk_results.size() == 0) begin
            $display("%0t unexpected beat: expected none actual status 0x%0h", $time,
                     rsp_status);
            error_count++;
         end else begin
            want = awaited_walk_results.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_status));
            check_field("mapped", 64'(want.mapped), 64'(rsp_mapped));
            check_field("page_base", 64'(want.page_base), 64'(rsp_page_base));
            check_field("tlb_flush", 64'(want.tlb_flush), 64'(rsp_tlb_flush));
         end
      end
   end

   initial begin
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (holdoff_cycles > 0) begin
            holdoff_cycles--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = idle_length(rsp_stall_pct);
            rsp_stall <= (stall_left != 0);
            if (stall_left != 0) stall_left--;
         end
      end
   end

   task automatic test_directed();
      send_idle_pct = 10;
      rsp_stall_pct = 10;
      send_request(OP_LOOKUP, 48'h0, 52'h0, 12'h000);
      send_request(OP_UNMAP, 48'h0, 52'h0, 12'h000);
      send_request(OP_MAP, 48'h0, '1, 12'h000);
      send_request(OP_LOOKUP, 48'hFFF, 52'h0, 12'h000);
      send_request(OP_MAP, 48'h0, 52'h0, 12'hFFF);
      send_request(OP_MAP, '1, 52'h0, 12'hFFF);
      send_request(OP_LOOKUP, '1, 52'h0, 12'h000);
      send_request(OP_MAP, 48'h1000, 52'h5_5555_5555_5555, 12'hAAA);
      send_request(OP_LOOKUP, 48'h1000, 52'h0, 12'h000);
      send_request(OP_LOOKUP, 48'h20_0000, 52'h0, 12'h000);
      send_request(OP_UNMAP, '1, 52'h0, 12'h000);
      send_request(OP_UNMAP, '1, 52'h0, 12'h000);
      send_request(OP_LOOKUP, '1, 52'h0, 12'h000);
      send_request(OP_MAP, '1, 52'hA_AAAA_AAAA_AAAA, 12'h555);
      send_request(OP_NOP, '1, '1, '1);
      send_request(OP_NOP, 48'h0, 52'h0, 12'h000);
      send_request(OP_UNMAP, 48'h2000, 52'h0, 12'h000);
      send_request(OP_LOOKUP, 48'h1234, 52'h0, 12'h000);
      send_request(OP_MAP, 48'h8000_0000_0000, 52'h1_2345_6789_A000, 12'h0F0);
      send_request(OP_LOOKUP, 48'h8000_0000_0000, 52'h0, 12'h000);
   endtask

   task automatic test_pool_exhaustion();
      logic [VA_W-1:0] va;
      int unsigned     top;
      bit              residue_fixed;
      top = 16;
      residue_fixed = 1'b0;
      va = '0;
      // leave one or two pages so that the last walk allocates only part of its path
      while (mirror_next_page < TABLE_PAGES) begin
         va = VA_W'({$urandom, $urandom});
         if (!residue_fixed && top > 16 && (TABLE_PAGES - mirror_next_page) % 3 == 0) begin
            va[VA_W-1:PATH_LSB] = {9'd16, 9'd0, 9'd300};
            residue_fixed = 1'b1;
         end else begin
            va[VA_W-1:PATH_LSB] = {IDX_W'(top), 18'd0};
            top++;
         end
         send_request(OP_MAP, va, PA_W'({$urandom, $urandom}), FLAG_W'($urandom));
      end
      send_request(OP_LOOKUP, va, 52'h0, 12'h000);
      send_request(OP_MAP, {IDX_W'(top), 39'h0}, '1, 12'h0FF);
      send_request(OP_LOOKUP, {IDX_W'(top), 39'h0}, 52'h0, 12'h000);
      send_request(OP_MAP, {9'd16, 9'd0, 9'd300, 9'd7, 12'h000}, 52'h0_0000_1234_5000,
                   12'h003);
      send_request(OP_LOOKUP, {9'd16, 9'd0, 9'd300, 9'd7, 12'hABC}, 52'h0, 12'h000);
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      holdoff_cycles = HOLDOFF_LEN;
      repeat (40) send_random_request();
   endtask

   task automatic test_random_traffic();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         send_idle_pct = 25 * ((n / 100) % 3);
         rsp_stall_pct = 15 * (((n / 100) + 1) % 3);
         send_random_request();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_pool_exhaustion();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (awaited_walk_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("page_table_walk_map_unmap_top verification clean");
      end else begin
         $display("page_table_walk_map_unmap_top verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ptw_pkg.sv
design/ptw_datapath.sv
design/ptw_ctrl.sv
design/page_table_walk_map_unmap_top.sv
verif/page_table_walk_map_unmap_top_tb.sv
